/* rtl/bpms_pkg.sv */
// ----------------------------------------------------------------------------
// bpms_pkg
// Types and constants shared by the battery power mode supervisor.
// ----------------------------------------------------------------------------
package bpms_pkg;

	// Field widths.
	localparam int unsigned CHARGE_W   = 10;
	localparam int unsigned MV_W       = 14;
	localparam int unsigned MW_W       = 14;
	localparam int unsigned DWELL_CFG_W = 16;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	// Power modes. Code 3 is never produced.
	typedef enum logic [1:0] {
		PM_SAFE    = 2'd0,
		PM_NOMINAL = 2'd1,
		PM_SCIENCE = 2'd2
	} mode_t;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SOC        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXIT_SOC         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_SOC         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOC_EMERGENCY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_MV        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LOAD_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SAFE_DWELL_TICKS = 3'd6;

	// Register reset values.
	localparam logic [CHARGE_W-1:0]    RST_ENTRY_SOC        = 10'd200;
	localparam logic [CHARGE_W-1:0]    RST_EXIT_SOC         = 10'd700;
	localparam logic [CHARGE_W-1:0]    RST_GATE_SOC         = 10'd600;
	localparam logic [CHARGE_W-1:0]    RST_SOC_EMERGENCY    = 10'd100;
	localparam logic [MV_W-1:0]        RST_CUTOFF_MV        = 14'd6000;
	localparam logic [MW_W-1:0]        RST_PEAK_LOAD_LIMIT  = 14'd5800;
	localparam logic [DWELL_CFG_W-1:0] RST_SAFE_DWELL_TICKS = 16'd11352;

	// Allowed passes per day below and above the science gate.
	localparam logic [1:0] PASSES_LOW  = 2'd2;
	localparam logic [1:0] PASSES_HIGH = 2'd3;

	// Configuration register file contents.
	typedef struct packed {
		logic [CHARGE_W-1:0]    entry_soc;
		logic [CHARGE_W-1:0]    exit_soc;
		logic [CHARGE_W-1:0]    gate_soc;
		logic [CHARGE_W-1:0]    soc_emergency;
		logic [MV_W-1:0]        cutoff_mv;
		logic [MW_W-1:0]        peak_load_limit;
		logic [DWELL_CFG_W-1:0] safe_dwell_ticks;
	} cfg_t;

	// One telemetry sample.
	typedef struct packed {
		logic [CHARGE_W-1:0] charge_permille;
		logic [MV_W-1:0]     battery_millivolts;
		logic [MW_W-1:0]     load_milliwatts;
		logic                uhf_pa_on;
		logic                sband_tx_on;
	} item_t;

	// One supervisor decision.
	typedef struct packed {
		logic [1:0] power_mode;
		logic [1:0] allowed_passes;
		logic       safe_entered;
		logic       payload_all_off;
		logic       attitude_min_power;
		logic       sband_block;
		logic       shed_payload;
		logic       emergency;
	} result_t;

endpackage

/* rtl/bpms_if.sv */
// ----------------------------------------------------------------------------
// bpms_if
// Valid/ready channels for telemetry samples and supervisor decisions.
// ----------------------------------------------------------------------------

// Telemetry sample channel.
interface bpms_sample_if;
	logic                          valid;
	logic                          ready;
	logic [bpms_pkg::CHARGE_W-1:0] charge_permille;
	logic [bpms_pkg::MV_W-1:0]     battery_millivolts;
	logic [bpms_pkg::MW_W-1:0]     load_milliwatts;
	logic                          uhf_pa_on;
	logic                          sband_tx_on;

	modport source (
		output valid, charge_permille, battery_millivolts, load_milliwatts,
		       uhf_pa_on, sband_tx_on,
		input  ready
	);
	modport sink (
		input  valid, charge_permille, battery_millivolts, load_milliwatts,
		       uhf_pa_on, sband_tx_on,
		output ready
	);
endinterface

// Decision channel.
interface bpms_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] power_mode;
	logic [1:0] allowed_passes;
	logic       safe_entered;
	logic       payload_all_off;
	logic       attitude_min_power;
	logic       sband_block;
	logic       shed_payload;
	logic       emergency;

	modport source (
		output valid, power_mode, allowed_passes, safe_entered, payload_all_off,
		       attitude_min_power, sband_block, shed_payload, emergency,
		input  ready
	);
	modport sink (
		input  valid, power_mode, allowed_passes, safe_entered, payload_all_off,
		       attitude_min_power, sband_block, shed_payload, emergency,
		output ready
	);
endinterface

/* rtl/battery_power_mode_supervisor.sv */
// ----------------------------------------------------------------------------
// battery_power_mode_supervisor
// Picks the spacecraft power mode and power actions from battery telemetry.
// ----------------------------------------------------------------------------
// Each accepted sample yields exactly one decision. The block takes one
// sample per clock cycle while the decision output is not stalled; a sample
// is held in the input register and its decision is loaded into the decision
// register, where it is presented. The mode and dwell counter update in the
// same cycle that the decision is loaded.
// A stalled decision output holds the pipeline but the input keeps accepting
// until the input register is also full. Thresholds are written through the
// configuration port and should only change while no sample is in flight.
module battery_power_mode_supervisor #(
	parameter int unsigned DWELL_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bpms_sample_if.sink                      sample,
	bpms_result_if.source                    result,
	input  logic                             cfg_wr_en,
	input  logic [bpms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpms_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bpms_pkg::cfg_t    cfg;
	bpms_pkg::item_t   item_s1;
	logic              valid_s1;
	bpms_pkg::result_t decision, result_q;
	logic              valid_q;
	logic              advance, take_in;

	bpms_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Pipeline flow control.
	assign advance      = valid_s1 && (!valid_q || result.ready);
	assign sample.ready = !valid_s1 || !valid_q || result.ready;
	assign take_in      = sample.valid && sample.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.charge_permille    <= sample.charge_permille;
			item_s1.battery_millivolts <= sample.battery_millivolts;
			item_s1.load_milliwatts    <= sample.load_milliwatts;
			item_s1.uhf_pa_on          <= sample.uhf_pa_on;
			item_s1.sband_tx_on        <= sample.sband_tx_on;
		end
	end

	bpms_rules #(
		.DWELL_WIDTH (DWELL_WIDTH)
	) u_rules (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (decision)
	);

	// Decision register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result.ready) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= decision;
		end
	end

	assign result.valid              = valid_q;
	assign result.power_mode         = result_q.power_mode;
	assign result.allowed_passes     = result_q.allowed_passes;
	assign result.safe_entered       = result_q.safe_entered;
	assign result.payload_all_off    = result_q.payload_all_off;
	assign result.attitude_min_power = result_q.attitude_min_power;
	assign result.sband_block        = result_q.sband_block;
	assign result.shed_payload       = result_q.shed_payload;
	assign result.emergency          = result_q.emergency;

endmodule

/* rtl/bpms_cfg.sv */
// ----------------------------------------------------------------------------
// bpms_cfg
// Threshold register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bpms_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bpms_pkg::CFG_IDX_W-1:0]   index,
	input  logic [bpms_pkg::CFG_DATA_W-1:0]  data,
	output bpms_pkg::cfg_t                   cfg
);

	bpms_pkg::cfg_t cfg_q;

	// Each register keeps the low bits of the write data; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_soc        <= bpms_pkg::RST_ENTRY_SOC;
			cfg_q.exit_soc         <= bpms_pkg::RST_EXIT_SOC;
			cfg_q.gate_soc         <= bpms_pkg::RST_GATE_SOC;
			cfg_q.soc_emergency    <= bpms_pkg::RST_SOC_EMERGENCY;
			cfg_q.cutoff_mv        <= bpms_pkg::RST_CUTOFF_MV;
			cfg_q.peak_load_limit  <= bpms_pkg::RST_PEAK_LOAD_LIMIT;
			cfg_q.safe_dwell_ticks <= bpms_pkg::RST_SAFE_DWELL_TICKS;
		end else if (wr_en) begin
			case (index)
				bpms_pkg::CFG_ENTRY_SOC:
					cfg_q.entry_soc <= data[bpms_pkg::CHARGE_W-1:0];
				bpms_pkg::CFG_EXIT_SOC:
					cfg_q.exit_soc <= data[bpms_pkg::CHARGE_W-1:0];
				bpms_pkg::CFG_GATE_SOC:
					cfg_q.gate_soc <= data[bpms_pkg::CHARGE_W-1:0];
				bpms_pkg::CFG_SOC_EMERGENCY:
					cfg_q.soc_emergency <= data[bpms_pkg::CHARGE_W-1:0];
				bpms_pkg::CFG_CUTOFF_MV:
					cfg_q.cutoff_mv <= data[bpms_pkg::MV_W-1:0];
				bpms_pkg::CFG_PEAK_LOAD_LIMIT:
					cfg_q.peak_load_limit <= data[bpms_pkg::MW_W-1:0];
				bpms_pkg::CFG_SAFE_DWELL_TICKS:
					cfg_q.safe_dwell_ticks <= data[bpms_pkg::DWELL_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/bpms_rules.sv */
// ----------------------------------------------------------------------------
// bpms_rules
// Mode register, dwell counter and the per-tick decision logic.
// ----------------------------------------------------------------------------
module bpms_rules #(
	parameter int unsigned DWELL_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  bpms_pkg::item_t   item,
	input  bpms_pkg::cfg_t    cfg,
	output bpms_pkg::result_t result
);

	localparam int unsigned CMP_W =
		(DWELL_WIDTH > bpms_pkg::DWELL_CFG_W) ? DWELL_WIDTH : bpms_pkg::DWELL_CFG_W;

	bpms_pkg::mode_t        mode_q, mode_d;
	logic [DWELL_WIDTH-1:0] ticks_q, ticks_d, ticks_inc;
	logic [CMP_W-1:0]       ticks_ext, dwell_ext;
	logic                   force_safe, dwell_ok, entered, emerg;

	// Saturating tick count, advanced at the start of every tick.
	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
	assign ticks_ext = CMP_W'(ticks_inc);
	assign dwell_ext = CMP_W'(cfg.safe_dwell_ticks);
	assign dwell_ok  = ticks_ext >= dwell_ext;

	assign force_safe = (item.charge_permille < cfg.entry_soc) ||
	                    (item.battery_millivolts < cfg.cutoff_mv);
	assign emerg      = item.charge_permille < cfg.soc_emergency;

	// Mode rules in priority order; the low-battery rule overrides the rest.
	always_comb begin
		mode_d  = mode_q;
		ticks_d = ticks_inc;
		entered = 1'b0;
		if (force_safe) begin
			if (mode_q != bpms_pkg::PM_SAFE) begin
				mode_d  = bpms_pkg::PM_SAFE;
				ticks_d = '0;
				entered = 1'b1;
			end
		end else begin
			case (mode_q)
				bpms_pkg::PM_SAFE: begin
					if (item.charge_permille > cfg.exit_soc && dwell_ok)
						mode_d = bpms_pkg::PM_NOMINAL;
				end
				bpms_pkg::PM_NOMINAL: begin
					if (item.charge_permille > cfg.gate_soc)
						mode_d = bpms_pkg::PM_SCIENCE;
				end
				bpms_pkg::PM_SCIENCE: begin
					if (item.charge_permille < cfg.gate_soc)
						mode_d = bpms_pkg::PM_NOMINAL;
				end
				default: begin
				end
			endcase
		end
	end

	// State moves only when the sample in the input register is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bpms_pkg::PM_SAFE;
			ticks_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			ticks_q <= ticks_d;
		end
	end

	// Decision fields.
	always_comb begin
		result.power_mode         = mode_d;
		result.allowed_passes     = (item.charge_permille < cfg.gate_soc) ?
		                            bpms_pkg::PASSES_LOW : bpms_pkg::PASSES_HIGH;
		result.safe_entered       = entered;
		result.payload_all_off    = entered || emerg;
		result.attitude_min_power = entered;
		result.sband_block        = item.uhf_pa_on && item.sband_tx_on;
		result.shed_payload       = item.load_milliwatts > cfg.peak_load_limit;
		result.emergency          = emerg;
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the battery power mode supervisor. A queue of
// telemetry samples feeds a clocked driver; every accepted request runs
// through a local model of the mode rules, and a clocked monitor compares
// each decision with the oldest predicted one. Threshold registers are
// changed only between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned DWELL_W     = 16;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned HOLD_ITEMS  = 180;

	// Local copies of the package widths, usable as cast sizes.
	localparam int unsigned SOC_W  = bpms_pkg::CHARGE_W;
	localparam int unsigned MV_W   = bpms_pkg::MV_W;
	localparam int unsigned MW_W   = bpms_pkg::MW_W;
	localparam int unsigned DW_W   = bpms_pkg::DWELL_CFG_W;
	localparam int unsigned DATA_W = bpms_pkg::CFG_DATA_W;
	localparam int unsigned IDX_W  = bpms_pkg::CFG_IDX_W;

	// Register index that decodes to nothing.
	localparam logic [IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;

	bpms_sample_if tel_ch ();
	bpms_result_if dec_ch ();

	battery_power_mode_supervisor #(
		.DWELL_WIDTH(DWELL_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (tel_ch),
		.result    (dec_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Samples waiting to be sent and decisions waiting to come back.
	bpms_pkg::item_t   pending_samples[$];
	bpms_pkg::result_t expected_decisions[$];
	bpms_pkg::item_t   on_wire;
	int unsigned samples_queued = 0;
	int unsigned decisions_seen = 0;
	int unsigned fail_count     = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_idle_pct  = 0;

	// Local copy of the thresholds, the mode and the dwell counter.
	bpms_pkg::cfg_t     tb_cfg;
	bpms_pkg::mode_t    tb_mode;
	logic [DWELL_W-1:0] tb_ticks;

	// Apply the mode rules to one sample and return the decision it yields.
	function automatic bpms_pkg::result_t predict_decision(bpms_pkg::item_t s);
		bpms_pkg::result_t r;
		logic              entered;
		logic              emerg;
		entered = 1'b0;
		if (tb_ticks != '1)
			tb_ticks = tb_ticks + 1'b1;
		if (s.charge_permille < tb_cfg.entry_soc ||
		    s.battery_millivolts < tb_cfg.cutoff_mv) begin
			// Already safe: no change and no counter clear.
			if (tb_mode != bpms_pkg::PM_SAFE) begin
				tb_mode  = bpms_pkg::PM_SAFE;
				tb_ticks = '0;
				entered  = 1'b1;
			end
		end else if (tb_mode == bpms_pkg::PM_SAFE &&
		             s.charge_permille > tb_cfg.exit_soc) begin
			if (32'(tb_ticks) >= 32'(tb_cfg.safe_dwell_ticks))
				tb_mode = bpms_pkg::PM_NOMINAL;
		end else if (tb_mode == bpms_pkg::PM_NOMINAL &&
		             s.charge_permille > tb_cfg.gate_soc) begin
			tb_mode = bpms_pkg::PM_SCIENCE;
		end else if (tb_mode == bpms_pkg::PM_SCIENCE &&
		             s.charge_permille < tb_cfg.gate_soc) begin
			tb_mode = bpms_pkg::PM_NOMINAL;
		end
		emerg = s.charge_permille < tb_cfg.soc_emergency;
		r.power_mode         = tb_mode;
		r.allowed_passes     = (s.charge_permille < tb_cfg.gate_soc) ?
		                       bpms_pkg::PASSES_LOW : bpms_pkg::PASSES_HIGH;
		r.safe_entered       = entered;
		r.payload_all_off    = entered | emerg;
		r.attitude_min_power = entered;
		r.sband_block        = s.uhf_pa_on & s.sband_tx_on;
		r.shed_payload       = s.load_milliwatts > tb_cfg.peak_load_limit;
		r.emergency          = emerg;
		return r;
	endfunction

	// Request driver: predicts on acceptance, then offers the next sample.
	always @(posedge clk) begin
		if (!arst_n) begin
			tel_ch.valid <= 1'b0;
		end else begin
			if (tel_ch.valid && tel_ch.ready)
				expected_decisions.push_back(predict_decision(on_wire));
			if (!tel_ch.valid || tel_ch.ready) begin
				if (pending_samples.size() != 0 &&
				    $urandom_range(99) >= send_idle_pct) begin
					on_wire = pending_samples.pop_front();
					{tel_ch.charge_permille, tel_ch.battery_millivolts,
					 tel_ch.load_milliwatts, tel_ch.uhf_pa_on,
					 tel_ch.sband_tx_on} <= on_wire;
					tel_ch.valid <= 1'b1;
				end else begin
					tel_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Decision monitor: checks against the oldest prediction, paces ready.
	always @(posedge clk) begin
		bpms_pkg::result_t got;
		bpms_pkg::result_t want;
		if (!arst_n) begin
			dec_ch.ready <= 1'b0;
		end else begin
			if (dec_ch.valid && dec_ch.ready) begin
				got = {dec_ch.power_mode, dec_ch.allowed_passes, dec_ch.safe_entered,
				       dec_ch.payload_all_off, dec_ch.attitude_min_power,
				       dec_ch.sband_block, dec_ch.shed_payload, dec_ch.emergency};
				decisions_seen++;
				if (expected_decisions.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("decision %0d arrived with none expected: mode=%0d",
						         decisions_seen, got.power_mode);
				end else begin
					want = expected_decisions.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"decision %0d: expected mode=%0d passes=%0d ",
							          "flags(entered,alloff,att,sband,shed,emerg)=%b, ",
							          "got mode=%0d passes=%0d flags=%b"},
							         decisions_seen, want.power_mode, want.allowed_passes,
							         want[5:0], got.power_mode, got.allowed_passes, got[5:0]);
					end
				end
			end
			dec_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on cycles in which no request and no decision moves.
	always @(posedge clk) begin
		if ((tel_ch.valid && tel_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("battery_power_mode_supervisor: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One register write on the configuration port, mirrored locally.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			bpms_pkg::CFG_ENTRY_SOC:        tb_cfg.entry_soc       = data[SOC_W-1:0];
			bpms_pkg::CFG_EXIT_SOC:         tb_cfg.exit_soc        = data[SOC_W-1:0];
			bpms_pkg::CFG_GATE_SOC:         tb_cfg.gate_soc        = data[SOC_W-1:0];
			bpms_pkg::CFG_SOC_EMERGENCY:    tb_cfg.soc_emergency   = data[SOC_W-1:0];
			bpms_pkg::CFG_CUTOFF_MV:        tb_cfg.cutoff_mv       = data[MV_W-1:0];
			bpms_pkg::CFG_PEAK_LOAD_LIMIT:  tb_cfg.peak_load_limit = data[MW_W-1:0];
			bpms_pkg::CFG_SAFE_DWELL_TICKS: tb_cfg.safe_dwell_ticks = data[DW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_cfg(bpms_pkg::cfg_t c);
		write_reg(bpms_pkg::CFG_ENTRY_SOC,        DATA_W'(c.entry_soc));
		write_reg(bpms_pkg::CFG_EXIT_SOC,         DATA_W'(c.exit_soc));
		write_reg(bpms_pkg::CFG_GATE_SOC,         DATA_W'(c.gate_soc));
		write_reg(bpms_pkg::CFG_SOC_EMERGENCY,    DATA_W'(c.soc_emergency));
		write_reg(bpms_pkg::CFG_CUTOFF_MV,        DATA_W'(c.cutoff_mv));
		write_reg(bpms_pkg::CFG_PEAK_LOAD_LIMIT,  DATA_W'(c.peak_load_limit));
		write_reg(bpms_pkg::CFG_SAFE_DWELL_TICKS, DATA_W'(c.safe_dwell_ticks));
	endtask

	// Same raw word to every register; upper bits beyond a width are dropped.
	task automatic fill_cfg(logic [DATA_W-1:0] data);
		write_reg(bpms_pkg::CFG_ENTRY_SOC,        data);
		write_reg(bpms_pkg::CFG_EXIT_SOC,         data);
		write_reg(bpms_pkg::CFG_GATE_SOC,         data);
		write_reg(bpms_pkg::CFG_SOC_EMERGENCY,    data);
		write_reg(bpms_pkg::CFG_CUTOFF_MV,        data);
		write_reg(bpms_pkg::CFG_PEAK_LOAD_LIMIT,  data);
		write_reg(bpms_pkg::CFG_SAFE_DWELL_TICKS, data);
	endtask

	function automatic bpms_pkg::cfg_t random_cfg();
		bpms_pkg::cfg_t c;
		c.entry_soc        = SOC_W'($urandom_range(300));
		c.exit_soc         = SOC_W'($urandom_range(1000, 32'(c.entry_soc)));
		c.gate_soc         = SOC_W'($urandom_range(1000));
		c.soc_emergency    = SOC_W'($urandom_range(300));
		c.cutoff_mv        = MV_W'($urandom_range(8000, 4000));
		c.peak_load_limit  = MW_W'($urandom_range(16383));
		c.safe_dwell_ticks = DW_W'($urandom_range(20));
		return c;
	endfunction

	// A value next to a threshold, kept inside [lo, hi].
	function automatic int clamp_near(int thr, int lo, int hi);
		int v;
		v = thr + int'($urandom_range(2)) - 1;
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	function automatic bpms_pkg::item_t mk_sample(int soc, int mv, int mw, bit uhf, bit sband);
		bpms_pkg::item_t s;
		s.charge_permille    = SOC_W'(soc);
		s.battery_millivolts = MV_W'(mv);
		s.load_milliwatts    = MW_W'(mw);
		s.uhf_pa_on          = uhf;
		s.sband_tx_on        = sband;
		return s;
	endfunction

	// Mostly healthy telemetry around the thresholds, some brown-outs,
	// and some fully random words.
	function automatic bpms_pkg::item_t gen_sample(int unsigned low_pct);
		int unsigned roll;
		int          soc;
		int          mv;
		int          mw;
		int          soc_lo;
		int          mv_lo;
		roll   = $urandom_range(99);
		soc_lo = int'(tb_cfg.entry_soc);
		mv_lo  = int'(tb_cfg.cutoff_mv);
		mw     = ($urandom_range(9) < 4) ?
		         clamp_near(int'(tb_cfg.peak_load_limit), 0, 16383) :
		         $urandom_range(16383);
		if (roll < 10) begin
			soc = $urandom_range(1023);
			mv  = $urandom_range(16383);
		end else if (roll < 10 + low_pct) begin
			soc = $urandom_range(1023);
			mv  = $urandom_range(16383);
			if ($urandom_range(1) && soc_lo > 0)
				soc = $urandom_range(soc_lo - 1, 0);
			else if (mv_lo > 0)
				mv = $urandom_range(mv_lo - 1, 0);
		end else begin
			case ($urandom_range(3))
				0:       soc = clamp_near(int'(tb_cfg.exit_soc), soc_lo, 1023);
				1:       soc = clamp_near(int'(tb_cfg.gate_soc), soc_lo, 1023);
				2:       soc = clamp_near(int'(tb_cfg.soc_emergency), soc_lo, 1023);
				default: soc = $urandom_range(1023, soc_lo);
			endcase
			mv = ($urandom_range(9) < 3) ? clamp_near(mv_lo, mv_lo, 16383) :
			     $urandom_range(16383, mv_lo);
		end
		return mk_sample(soc, mv, mw, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endfunction

	task automatic queue_sample(bpms_pkg::item_t s);
		pending_samples.push_back(s);
		samples_queued++;
	endtask

	// Wait until every queued sample has produced its decision.
	task automatic wait_idle();
		while (decisions_seen != samples_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(int unsigned n, int unsigned low_pct);
		repeat (n) queue_sample(gen_sample(low_pct));
		wait_idle();
	endtask

	// Stimulus sequence.
	initial begin
		bpms_pkg::cfg_t c;
		arst_n                    = 1'b0;
		cfg_wr_en                 = 1'b0;
		cfg_index                 = '0;
		cfg_data                  = '0;
		tel_ch.valid              = 1'b0;
		tel_ch.charge_permille    = '0;
		tel_ch.battery_millivolts = '0;
		tel_ch.load_milliwatts    = '0;
		tel_ch.uhf_pa_on          = 1'b0;
		tel_ch.sband_tx_on        = 1'b0;
		dec_ch.ready              = 1'b0;
		tb_cfg = '{entry_soc: bpms_pkg::RST_ENTRY_SOC, exit_soc: bpms_pkg::RST_EXIT_SOC,
		           gate_soc: bpms_pkg::RST_GATE_SOC,
		           soc_emergency: bpms_pkg::RST_SOC_EMERGENCY,
		           cutoff_mv: bpms_pkg::RST_CUTOFF_MV,
		           peak_load_limit: bpms_pkg::RST_PEAK_LOAD_LIMIT,
		           safe_dwell_ticks: bpms_pkg::RST_SAFE_DWELL_TICKS};
		tb_mode  = bpms_pkg::PM_SAFE;
		tb_ticks = '0;
		send_idle_pct = 32;
		recv_idle_pct = 48;

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset thresholds: field extremes and threshold edges while held
		// in safe mode by the long dwell.
		queue_sample(mk_sample(0, 0, 0, 1'b0, 1'b0));
		queue_sample(mk_sample(1023, 16383, 16383, 1'b1, 1'b1));
		queue_sample(mk_sample(200, 6000, 5800, 1'b1, 1'b0));
		queue_sample(mk_sample(199, 6000, 5801, 1'b0, 1'b1));
		queue_sample(mk_sample(100, 5999, 0, 1'b1, 1'b1));
		queue_sample(mk_sample(99, 7000, 5799, 1'b0, 1'b0));
		queue_sample(mk_sample(701, 7000, 100, 1'b0, 1'b0));
		queue_sample(mk_sample(1000, 16383, 200, 1'b1, 1'b0));
		wait_idle();

		// Short dwell: walk from safe to nominal, science, back to nominal and into safe.
		write_reg(bpms_pkg::CFG_SAFE_DWELL_TICKS, 16'd3);
		queue_sample(mk_sample(800, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(601, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(600, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(1023, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(599, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(600, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(150, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(50, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(701, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(701, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(601, 7000, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(900, 5999, 1000, 1'b0, 1'b0));
		queue_sample(mk_sample(700, 7000, 1000, 1'b0, 1'b0));
		wait_idle();

		// Random thresholds, then all registers at zero.
		apply_cfg(random_cfg());
		run_random(250, 10);
		fill_cfg('0);
		run_random(150, 10);

		// Receiver now the faster side; also a write to the unused index.
		send_idle_pct = 48;
		recv_idle_pct = 32;
		apply_cfg(random_cfg());
		write_reg(CFG_UNUSED_IDX, '1);
		run_random(250, 15);
		// Every register at its top value, upper bits beyond each width set.
		fill_cfg('1);
		run_random(150, 10);

		// No idling from here on.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		c = random_cfg();
		c.safe_dwell_ticks = '0;
		apply_cfg(c);
		run_random(250, 20);
		apply_cfg(random_cfg());
		run_random(250, 10);

		// Longest dwell: after a low-charge sample forces safe mode, safe mode holds throughout.
		c = '{entry_soc: bpms_pkg::RST_ENTRY_SOC, exit_soc: bpms_pkg::RST_EXIT_SOC,
		      gate_soc: bpms_pkg::RST_GATE_SOC,
		      soc_emergency: bpms_pkg::RST_SOC_EMERGENCY,
		      cutoff_mv: bpms_pkg::RST_CUTOFF_MV,
		      peak_load_limit: bpms_pkg::RST_PEAK_LOAD_LIMIT,
		      safe_dwell_ticks: '1};
		apply_cfg(c);
		queue_sample(mk_sample(0, 7000, 0, 1'b0, 1'b0));
		repeat (HOLD_ITEMS)
			queue_sample(mk_sample($urandom_range(1023, 701), $urandom_range(16383, 6000),
			                       $urandom_range(16383), 1'($urandom_range(1)),
			                       1'($urandom_range(1))));
		wait_idle();

		repeat (4) @(posedge clk);
		if (fail_count == 0 && expected_decisions.size() == 0)
			$display("battery_power_mode_supervisor: match");
		else
			$display("battery_power_mode_supervisor: mismatch");
		$finish;
	end

endmodule
